[hdl/amac_pkg.sv]
// ----------------------------------------------------------------------------
// amac_pkg: shared types for the multiply-accumulate unit
// Operation codes, the decoded request that the front end queues for the
// execute pipeline, and the result record that leaves it.
// ----------------------------------------------------------------------------
`default_nettype none

package amac_pkg;

  localparam int WORD_W = 32;
  localparam int HALF_W = 16;
  localparam int DUAL_W = 2 * HALF_W + 1;
  localparam logic [WORD_W-1:0] ROUND_CONST = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_MUL    = 4'd0,
    OP_MLA    = 4'd1,
    OP_UMULL  = 4'd2,
    OP_UMLAL  = 4'd3,
    OP_SMULL  = 4'd4,
    OP_SMLAL  = 4'd5,
    OP_UMAAL  = 4'd6,
    OP_SMUAD  = 4'd7,
    OP_SMUSD  = 4'd8,
    OP_SMLAD  = 4'd9,
    OP_SMLSD  = 4'd10,
    OP_SMLALD = 4'd11,
    OP_SMLSLD = 4'd12,
    OP_SMMUL  = 4'd13,
    OP_SMMLA  = 4'd14,
    OP_SMMLS  = 4'd15
  } op_e;

  // Control bits that steer the execute pipeline.
  typedef struct packed {
    logic mul_signed;   // 32x32 product treats both operands as signed
    logic dual;         // result built from the two 16x16 products
    logic dual_sub;     // second halfword product is subtracted
    logic neg_prod;     // 32x32 product is subtracted from the addend
    logic hi_word;      // result is the top word of the 64-bit sum
    logic long_res;     // two destination words are written
    logic q_check;      // signed 32-bit overflow sets Q
    logic flags_update; // N and Z are written
  } ctrl_t;

  typedef struct packed {
    ctrl_t             ctrl;
    logic [WORD_W-1:0] op_m;
    logic [WORD_W-1:0] op_s;      // halfword-swapped if dual and swap bit set
    logic [2*WORD_W-1:0] addend;  // 64-bit addend, zero when none
    logic [WORD_W-1:0] extra;     // second 32-bit addend for UMAAL
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
    logic              writes_high;
    logic              flags_update;
    logic              n_flag;
    logic              z_flag;
    logic              q_set;
  } res_t;

endpackage

`default_nettype wire

[hdl/amac_front.sv]
// ----------------------------------------------------------------------------
// amac_front: request classifier
// Turns an incoming request into control bits and pre-arranged operands.
// ----------------------------------------------------------------------------
`default_nettype none

module amac_front
  import amac_pkg::*;
(
  input  wire logic [3:0]        opcode,
  input  wire logic [WORD_W-1:0] op_m,
  input  wire logic [WORD_W-1:0] op_s,
  input  wire logic [WORD_W-1:0] addend_low,
  input  wire logic [WORD_W-1:0] addend_high,
  input  wire logic              set_flags,
  input  wire logic              swap_or_round,
  output cmd_t                   cmd
);

  logic [WORD_W-1:0] rnd;
  logic [WORD_W-1:0] s_rot;

  assign rnd   = swap_or_round ? ROUND_CONST : '0;
  assign s_rot = {op_s[HALF_W-1:0], op_s[WORD_W-1:HALF_W]};

  always_comb begin
    cmd.ctrl   = '0;
    cmd.op_m   = op_m;
    cmd.op_s   = op_s;
    cmd.addend = '0;
    cmd.extra  = '0;
    case (op_e'(opcode))
      OP_MUL: begin
        cmd.ctrl.flags_update = set_flags;
      end
      OP_MLA: begin
        cmd.ctrl.flags_update = set_flags;
        cmd.addend = {{WORD_W{1'b0}}, addend_low};
      end
      OP_UMULL: begin
        cmd.ctrl.flags_update = set_flags;
        cmd.ctrl.long_res = 1'b1;
      end
      OP_UMLAL: begin
        cmd.ctrl.flags_update = set_flags;
        cmd.ctrl.long_res = 1'b1;
        cmd.addend = {addend_high, addend_low};
      end
      OP_SMULL: begin
        cmd.ctrl.flags_update = set_flags;
        cmd.ctrl.long_res = 1'b1;
        cmd.ctrl.mul_signed = 1'b1;
      end
      OP_SMLAL: begin
        cmd.ctrl.flags_update = set_flags;
        cmd.ctrl.long_res = 1'b1;
        cmd.ctrl.mul_signed = 1'b1;
        cmd.addend = {addend_high, addend_low};
      end
      OP_UMAAL: begin
        cmd.ctrl.long_res = 1'b1;
        cmd.addend = {{WORD_W{1'b0}}, addend_low};
        cmd.extra  = addend_high;
      end
      OP_SMUAD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.q_check = 1'b1;
      end
      OP_SMUSD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.dual_sub = 1'b1;
      end
      OP_SMLAD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.q_check = 1'b1;
        cmd.addend = {{WORD_W{addend_low[WORD_W-1]}}, addend_low};
      end
      OP_SMLSD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.dual_sub = 1'b1;
        cmd.ctrl.q_check = 1'b1;
        cmd.addend = {{WORD_W{addend_low[WORD_W-1]}}, addend_low};
      end
      OP_SMLALD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.long_res = 1'b1;
        cmd.addend = {addend_high, addend_low};
      end
      OP_SMLSLD: begin
        cmd.ctrl.dual = 1'b1;
        cmd.ctrl.dual_sub = 1'b1;
        cmd.ctrl.long_res = 1'b1;
        cmd.addend = {addend_high, addend_low};
      end
      OP_SMMUL: begin
        cmd.ctrl.mul_signed = 1'b1;
        cmd.ctrl.hi_word = 1'b1;
        cmd.addend = {{WORD_W{1'b0}}, rnd};
      end
      OP_SMMLA: begin
        cmd.ctrl.mul_signed = 1'b1;
        cmd.ctrl.hi_word = 1'b1;
        cmd.addend = {addend_low, rnd};
      end
      OP_SMMLS: begin
        cmd.ctrl.mul_signed = 1'b1;
        cmd.ctrl.hi_word = 1'b1;
        cmd.ctrl.neg_prod = 1'b1;
        cmd.addend = {addend_low, rnd};
      end
      default: begin
        cmd.ctrl = '0;
      end
    endcase
    // Dual forms may swap the halves of the second operand.
    if (cmd.ctrl.dual && swap_or_round) begin
      cmd.op_s = s_rot;
    end
  end

endmodule

`default_nettype wire

[hdl/amac_queue.sv]
// ----------------------------------------------------------------------------
// amac_queue: decoded request queue
// Small first-in first-out buffer between the front end and the execute
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module amac_queue
  import amac_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output cmd_t      head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("request queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty)) else $error("request queue read while empty");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("request queue count out of range");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("request queue count did not follow a write");

endmodule

`default_nettype wire

[hdl/amac_back.sv]
// ----------------------------------------------------------------------------
// amac_back: execute pipeline
// Three stages: multiply, operand alignment, final 64-bit add into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module amac_back
  import amac_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  localparam int DW = 2 * WORD_W;

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic en1, en2, en3;
  logic v1, v2, v3;

  // Multiply stage.
  ctrl_t               c1;
  logic [DW-1:0]       prod1;
  logic signed [WORD_W-1:0] p1_1, p2_1;
  logic [DW-1:0]       b1;

  // Alignment stage.
  ctrl_t         c2;
  logic [DW-1:0] a2, b2;
  logic          cin2;

  logic signed [WORD_W:0]   mx, sx;
  logic signed [2*WORD_W+1:0] full_prod;
  logic signed [WORD_W-1:0] p1_n, p2_n;
  logic [DUAL_W-1:0]        d_sum;
  logic [DW-1:0]            a_n;
  logic [DW-1:0]            sum;
  res_t                     res_n;

  assign en3 = !v3 || res_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign cmd_ready = en1;
  assign res_valid = v3;

  // Stage 1 arithmetic.
  assign mx = $signed({cmd.ctrl.mul_signed & cmd.op_m[WORD_W-1], cmd.op_m});
  assign sx = $signed({cmd.ctrl.mul_signed & cmd.op_s[WORD_W-1], cmd.op_s});
  assign full_prod = mx * sx;
  assign p1_n = $signed(cmd.op_m[HALF_W-1:0]) * $signed(cmd.op_s[HALF_W-1:0]);
  assign p2_n = $signed(cmd.op_m[WORD_W-1:HALF_W]) * $signed(cmd.op_s[WORD_W-1:HALF_W]);

  // Stage 2 arithmetic.
  always_comb begin
    if (c1.dual_sub) begin
      d_sum = {p1_1[WORD_W-1], p1_1} - {p2_1[WORD_W-1], p2_1};
    end else begin
      d_sum = {p1_1[WORD_W-1], p1_1} + {p2_1[WORD_W-1], p2_1};
    end
    if (c1.dual) begin
      a_n = {{(DW-DUAL_W){d_sum[DUAL_W-1]}}, d_sum};
    end else if (c1.neg_prod) begin
      a_n = ~prod1;
    end else begin
      a_n = prod1;
    end
  end

  // Stage 3 arithmetic.
  always_comb begin
    sum = a2 + b2 + {{(DW-1){1'b0}}, cin2};
    res_n.result_low   = c2.hi_word ? sum[DW-1:WORD_W] : sum[WORD_W-1:0];
    res_n.result_high  = c2.long_res ? sum[DW-1:WORD_W] : '0;
    res_n.writes_high  = c2.long_res;
    res_n.flags_update = c2.flags_update;
    res_n.n_flag       = c2.flags_update &&
                         (c2.long_res ? sum[DW-1] : sum[WORD_W-1]);
    res_n.z_flag       = c2.flags_update && (res_n.result_low == '0) &&
                         (res_n.result_high == '0);
    res_n.q_set        = c2.q_check &&
                         !((&sum[DW-1:WORD_W-1]) || !(|sum[DW-1:WORD_W-1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= cmd_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      c1    <= cmd.ctrl;
      prod1 <= full_prod[DW-1:0];
      p1_1  <= p1_n;
      p2_1  <= p2_n;
      b1    <= cmd.addend + {{WORD_W{1'b0}}, cmd.extra};
    end
    if (en2) begin
      c2   <= c1;
      a2   <= a_n;
      b2   <= b1;
      cin2 <= c1.neg_prod && !c1.dual;
    end
    if (en3) begin
      res <= res_n;
    end
  end

  a_q_single_word: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.q_set) |-> (!res.writes_high && !res.flags_update))
    else $error("Q set on a long or flag-setting operation");

  a_flags_gated: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.n_flag || res.z_flag)) |-> res.flags_update)
    else $error("N or Z given without a flag update");

  a_high_word_gated: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.result_high != '0)) |-> res.writes_high)
    else $error("high word nonzero on a single-word operation");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (v2 && en3) |=> v3)
    else $error("aligned operands lost before the output register");

endmodule

`default_nettype wire

[hdl/arm_multiply_accumulate_unit.sv]
// ----------------------------------------------------------------------------
// arm_multiply_accumulate_unit: ARMv6 multiply-class execute unit
// Executes one multiply, long multiply, dual halfword or most-significant-word
// multiply operation per request on operand values read from the register file.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_axis channel: the four operand words travel in
// tdata and the opcode, S bit and swap/round bit in tuser. Results leave on
// the m_axis channel with the low and high destination words in tdata and the
// write-high, flag-update, N, Z and Q-set bits in tuser.
// A request is decoded on arrival and written into a four-entry queue; the
// execute pipeline then takes it through a multiply stage, an alignment
// stage and a final 64-bit add that loads the output register. One request
// per cycle is sustained while m_axis_tready stays high; every request
// passes once through the multiply stage, which holds one 33x33 and two
// 16x16 multipliers.
// When the receiver holds m_axis_tready low, the pipeline stages fill, then
// the queue fills, and s_axis_tready drops only when the queue is full.
// Reset clears the queue pointers and the pipeline valid bits; no result is
// presented until a new request arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_multiply_accumulate_unit
  import amac_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // op_m [31:0], op_s [63:32], addend_low [95:64], addend_high [127:96]
  input  wire logic [127:0] s_axis_tdata,
  // opcode [3:0], set_flags [4], swap_or_round [5], zero [7:6]
  input  wire logic [7:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_low [31:0], result_high [63:32]
  output logic [63:0]       m_axis_tdata,
  // writes_high [0], flags_update [1], n_flag [2], z_flag [3], q_set [4],
  // zero [7:5]
  output logic [7:0]        m_axis_tuser
);

  cmd_t dec_cmd;
  cmd_t head_cmd;
  res_t res;
  logic q_full;
  logic q_not_empty;
  logic back_ready;
  logic push;
  logic pop;

  // Classify the incoming request.
  amac_front u_front (
    .opcode        (s_axis_tuser[3:0]),
    .op_m          (s_axis_tdata[31:0]),
    .op_s          (s_axis_tdata[63:32]),
    .addend_low    (s_axis_tdata[95:64]),
    .addend_high   (s_axis_tdata[127:96]),
    .set_flags     (s_axis_tuser[4]),
    .swap_or_round (s_axis_tuser[5]),
    .cmd           (dec_cmd)
  );

  // The queue lets the input side keep accepting while the output stalls.
  assign s_axis_tready = !q_full;
  assign push = s_axis_tvalid && !q_full;
  assign pop  = q_not_empty && back_ready;

  amac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (dec_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  amac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_ready (back_ready),
    .cmd       (head_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.result_high, res.result_low};
  assign m_axis_tuser = {3'b000, res.q_set, res.z_flag, res.n_flag,
                         res.flags_update, res.writes_high};

endmodule

`default_nettype wire

[tb/arm_multiply_accumulate_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_multiply_accumulate_unit_tb: self-checking bench for the multiply unit
// A table of directed requests covers the operand extremes, every opcode, the
// overflow and rounding corners, and the cases where the S bit or the swap
// bit is ignored. Random requests follow. Expected results come from typed-in
// values on the plainest table rows and from a local model of the unit on
// every other request. Both stream sides idle at random, except during one
// long stretch at full rate.
// ----------------------------------------------------------------------------

module arm_multiply_accumulate_unit_tb;
  import amac_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_REQS  = 650;
  localparam int IDLE_PCT     = 22;
  localparam int QUIET_FIRST  = 250;
  localparam int QUIET_LAST   = 399;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200_000;

  // One request as the decoder sees it, before packing onto the bus.
  typedef struct {
    op_e         opcode;
    logic [31:0] op_m;
    logic [31:0] op_s;
    logic [31:0] addend_low;
    logic [31:0] addend_high;
    logic        set_flags;
    logic        swap_or_round;
  } mac_req_t;

  // A row of the directed table. Where typed is set, want holds the result
  // written out by hand; otherwise the local model supplies it.
  typedef struct {
    mac_req_t req;
    logic     typed;
    res_t     want;
  } mac_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [7:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [7:0] m_axis_tuser;

  res_t mac_results_due[$];
  mac_row_t mac_table[$];
  int mismatches = 0;
  int cycles = 0;
  logic quiet_run = 1'b0;

  arm_multiply_accumulate_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Result of one multiply-class operation, worked out in 64-bit arithmetic.
  function automatic res_t mac_compute(input mac_req_t r);
    logic [31:0] s_sw;
    longint lo_prod;
    longint hi_prod;
    longint wide;
    logic [63:0] acc;
    logic [63:0] uprod;
    logic [63:0] sprod;
    logic [63:0] rnd;
    logic [63:0] sum;
    logic two;
    logic ovf;
    logic [31:0] top;
    res_t o;
    s_sw = r.swap_or_round ? {r.op_s[15:0], r.op_s[31:16]} : r.op_s;
    lo_prod = longint'($signed(r.op_m[15:0])) * longint'($signed(s_sw[15:0]));
    hi_prod = longint'($signed(r.op_m[31:16])) * longint'($signed(s_sw[31:16]));
    acc = {r.addend_high, r.addend_low};
    uprod = {32'd0, r.op_m} * {32'd0, r.op_s};
    sprod = longint'($signed(r.op_m)) * longint'($signed(r.op_s));
    rnd = r.swap_or_round ? 64'h0000_0000_8000_0000 : 64'd0;
    two = 1'b0;
    ovf = 1'b0;
    wide = 0;
    sum = '0;
    case (r.opcode)
      OP_MUL: sum = {32'd0, uprod[31:0]};
      OP_MLA: sum = {32'd0, uprod[31:0] + r.addend_low};
      OP_UMULL: begin
        sum = uprod;
        two = 1'b1;
      end
      OP_UMLAL: begin
        sum = uprod + acc;
        two = 1'b1;
      end
      OP_SMULL: begin
        sum = sprod;
        two = 1'b1;
      end
      OP_SMLAL: begin
        sum = sprod + acc;
        two = 1'b1;
      end
      OP_UMAAL: begin
        sum = uprod + {32'd0, r.addend_low} + {32'd0, r.addend_high};
        two = 1'b1;
      end
      OP_SMUAD: wide = lo_prod + hi_prod;
      OP_SMUSD: wide = lo_prod - hi_prod;
      OP_SMLAD: wide = longint'($signed(r.addend_low)) + lo_prod + hi_prod;
      OP_SMLSD: wide = longint'($signed(r.addend_low)) + (lo_prod - hi_prod);
      OP_SMLALD: begin
        sum = acc + 64'(lo_prod + hi_prod);
        two = 1'b1;
      end
      OP_SMLSLD: begin
        sum = acc + 64'(lo_prod - hi_prod);
        two = 1'b1;
      end
      OP_SMMUL: sum = (sprod + rnd) >> 32;
      OP_SMMLA: sum = ({r.addend_low, 32'd0} + sprod + rnd) >> 32;
      default: sum = ({r.addend_low, 32'd0} - sprod + rnd) >> 32;
    endcase
    // The dual single-word forms build their result from the exact sum, and
    // all but SMUSD flag a sum that does not fit in 32 signed bits.
    if (r.opcode inside {OP_SMUAD, OP_SMUSD, OP_SMLAD, OP_SMLSD}) begin
      sum = 64'(wide);
      if (r.opcode != OP_SMUSD) ovf = !((&wide[63:31]) || !(|wide[63:31]));
    end
    o.result_low = sum[31:0];
    o.result_high = two ? sum[63:32] : 32'd0;
    o.writes_high = two;
    o.flags_update = r.set_flags && (r.opcode <= OP_SMLAL);
    top = two ? o.result_high : o.result_low;
    o.n_flag = o.flags_update && top[31];
    o.z_flag = o.flags_update && (o.result_low == 32'd0) && (o.result_high == 32'd0);
    o.q_set = ovf;
    return o;
  endfunction

  // Operand words lean toward the values where sign and carry matter.
  function automatic logic [31:0] pick_operand();
    logic [15:0] halves [5] = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff};
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return {halves[3'($urandom_range(0, 4))], halves[3'($urandom_range(0, 4))]};
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_row(input op_e op, input logic [31:0] m, input logic [31:0] s,
                                  input logic [31:0] lo, input logic [31:0] hi,
                                  input logic sf, input logic sr, input logic typed,
                                  input res_t want);
    mac_row_t row;
    row.req = '{op, m, s, lo, hi, sf, sr};
    row.typed = typed;
    row.want = want;
    mac_table.push_back(row);
  endfunction

  // Presents one request, with a random gap first unless the bench is in
  // its full-rate stretch, and books the expected result once it is taken.
  // Only one assignment to tvalid lands in any time step.
  task automatic send_request(input mac_req_t r, input res_t want);
    if (!quiet_run) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.addend_high, r.addend_low, r.op_s, r.op_m};
    s_axis_tuser <= {2'b00, r.swap_or_round, r.set_flags, r.opcode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    mac_results_due.push_back(want);
  endtask

  // The receiver stalls at random, except during the full-rate stretch.
  always @(posedge clk) begin
    m_axis_tready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Every result taken is matched against the oldest one still due.
  always @(posedge clk) begin
    res_t got;
    res_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tuser[1],
             m_axis_tuser[2], m_axis_tuser[3], m_axis_tuser[4]};
      if (mac_results_due.size() == 0) begin
        $error("result with nothing due: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        exp_res = mac_results_due.pop_front();
        if (got.result_low !== exp_res.result_low) begin
          $error("result_low: expected %h, got %h", exp_res.result_low, got.result_low);
          mismatches++;
        end
        if (got.result_high !== exp_res.result_high) begin
          $error("result_high: expected %h, got %h", exp_res.result_high, got.result_high);
          mismatches++;
        end
        if (got.writes_high !== exp_res.writes_high) begin
          $error("writes_high: expected %b, got %b", exp_res.writes_high, got.writes_high);
          mismatches++;
        end
        if (got.flags_update !== exp_res.flags_update) begin
          $error("flags_update: expected %b, got %b", exp_res.flags_update, got.flags_update);
          mismatches++;
        end
        if (got.n_flag !== exp_res.n_flag) begin
          $error("n_flag: expected %b, got %b", exp_res.n_flag, got.n_flag);
          mismatches++;
        end
        if (got.z_flag !== exp_res.z_flag) begin
          $error("z_flag: expected %b, got %b", exp_res.z_flag, got.z_flag);
          mismatches++;
        end
        if (got.q_set !== exp_res.q_set) begin
          $error("q_set: expected %b, got %b", exp_res.q_set, got.q_set);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("arm_multiply_accumulate_unit verification failed");
      $finish;
    end
  end

  initial begin
    mac_req_t req;
    res_t want;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;

    // Zero product with flags: only Z is set.
    add_row(OP_MUL, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
            res_t'{32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0});
    add_row(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
            res_t'{32'h1, 32'h0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
    // No flags requested, and the addends must be ignored.
    add_row(OP_MUL, 32'h1234_5678, 32'h9abc_def0, 32'hdead_beef, 32'hcafe_f00d, 1'b0, 1'b1,
            1'b0, '0);
    // Multiply-add that wraps to zero.
    add_row(OP_MLA, 32'hffff_ffff, 32'h1, 32'h1, 32'hffff_ffff, 1'b1, 1'b0, 1'b1,
            res_t'{32'h0, 32'h0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0});
    add_row(OP_UMULL, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
            res_t'{32'h1, 32'hffff_fffe, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    add_row(OP_UMLAL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0,
            1'b0, '0);
    add_row(OP_SMULL, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
            res_t'{32'h0, 32'h4000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
    add_row(OP_SMULL, 32'hffff_ffff, 32'h1, 32'h0, 32'h0, 1'b1, 1'b0, 1'b1,
            res_t'{32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0});
    add_row(OP_SMLAL, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000, 1'b1, 1'b0, 1'b0, '0);
    // Largest UMAAL sum: fits exactly, and the S bit is ignored.
    add_row(OP_UMAAL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0,
            1'b1, res_t'{32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0});
    // Two most-negative halfword squares overflow the dual add.
    add_row(OP_SMUAD, 32'h8000_8000, 32'h8000_8000, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1,
            res_t'{32'h8000_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(OP_SMUAD, 32'h7fff_8000, 32'h8000_7fff, 32'h0, 32'h0, 1'b1, 1'b1, 1'b0, '0);
    // The dual difference always fits, so Q stays clear.
    add_row(OP_SMUSD, 32'h8000_8000, 32'h7fff_8000, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_SMUSD, 32'h8000_7fff, 32'h8000_8000, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_SMLAD, 32'h0001_0001, 32'h0001_0001, 32'h7fff_ffff, 32'h0, 1'b0, 1'b0, 1'b1,
            res_t'{32'h8000_0001, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(OP_SMLAD, 32'h8000_7fff, 32'h7fff_8000, 32'h8000_0000, 32'h0, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_SMLSD, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 1'b1,
            res_t'{32'h7fff_ffff, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1});
    add_row(OP_SMLALD, 32'h8000_8000, 32'h8000_8000, 32'hffff_ffff, 32'h7fff_ffff, 1'b1, 1'b0,
            1'b0, '0);
    add_row(OP_SMLSLD, 32'h7fff_8000, 32'h8000_7fff, 32'h0, 32'h8000_0000, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_SMMUL, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1,
            res_t'{32'h4000_0000, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    // Rounding carries a negative product up to zero; without it the top
    // word stays all ones.
    add_row(OP_SMMUL, 32'h1, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 1'b1, 1'b1,
            res_t'{32'h0, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(OP_SMMUL, 32'h1, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1,
            res_t'{32'hffff_ffff, 32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
    add_row(OP_SMMLA, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0, 1'b1, 1'b0, '0);
    add_row(OP_SMMLS, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b0, 1'b0, 1'b0, '0);
    add_row(OP_SMMLS, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 1'b0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (mac_table[i]) begin
      want = mac_table[i].typed ? mac_table[i].want : mac_compute(mac_table[i].req);
      send_request(mac_table[i].req, want);
    end

    for (int i = 0; i < RANDOM_REQS; i++) begin
      quiet_run = (i >= QUIET_FIRST) && (i <= QUIET_LAST);
      req.opcode = op_e'($urandom_range(0, 15));
      req.op_m = pick_operand();
      req.op_s = pick_operand();
      req.addend_low = pick_operand();
      req.addend_high = pick_operand();
      req.set_flags = 1'($urandom_range(0, 1));
      req.swap_or_round = 1'($urandom_range(0, 1));
      send_request(req, mac_compute(req));
    end
    quiet_run = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (mac_results_due.size() != 0) @(posedge clk);
    // The drain wait catches any stray result behind the last one.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("arm_multiply_accumulate_unit verification clean");
    end else begin
      $display("arm_multiply_accumulate_unit verification failed");
    end
    $finish;
  end

endmodule
